FILE: rtl/c8e_pkg.sv
// ----------------------------------------------------------------------------
// c8e_pkg
// Shared types and constants for the instruction executor.
// ----------------------------------------------------------------------------
package c8e_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned FontBaseDef   = 0;
  localparam int unsigned FontHeightDef = 5;
  localparam int unsigned StepSizeDef   = 2;

  localparam int unsigned MemAw = 12;
  localparam int unsigned FbAw  = 8;

  typedef enum logic [1:0] {
    OP_EXEC = 2'd0,
    OP_MWR  = 2'd1,
    OP_MRD  = 2'd2,
    OP_FBRD = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ILL   = 2'd1,
    ST_UNIMP = 2'd2,
    ST_STACK = 2'd3
  } status_e;

  localparam logic [15:0] InsCls = 16'h00E0;
  localparam logic [15:0] InsRet = 16'h00EE;
  localparam logic [7:0]  FnGetDt  = 8'h07;
  localparam logic [7:0]  FnKey    = 8'h0A;
  localparam logic [7:0]  FnSetDt  = 8'h15;
  localparam logic [7:0]  FnSetSt  = 8'h18;
  localparam logic [7:0]  FnAddI   = 8'h1E;
  localparam logic [7:0]  FnFont   = 8'h29;
  localparam logic [7:0]  FnBcd    = 8'h33;
  localparam logic [7:0]  FnStore  = 8'h55;
  localparam logic [7:0]  FnLoad   = 8'h65;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] instruction;
    logic [7:0]  random_byte;
    logic [11:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [1:0]  status;
    logic [7:0]  read_data;
    logic        collision;
  } rsp_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_DRAW_RD,
    S_DRAW_WAIT,
    S_DRAW_PIX,
    S_BCD,
    S_STORE,
    S_LOAD_RD,
    S_LOAD_WAIT,
    S_MEM_WAIT,
    S_FB_WAIT,
    S_DONE
  } state_e;

  // byte-memory port request from the sequencer
  typedef struct packed {
    logic             we;
    logic [MemAw-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

  // framebuffer port request from the sequencer
  typedef struct packed {
    logic            we;
    logic [FbAw-1:0] addr;
    logic [7:0]      wdata;
  } fb_req_t;

endpackage

FILE: rtl/c8e_mem.sv
// ----------------------------------------------------------------------------
// c8e_mem
// Single-port byte RAM with registered read data.
// ----------------------------------------------------------------------------
module c8e_mem #(
  parameter int unsigned Aw = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [2**Aw];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: rtl/c8e_fb.sv
// ----------------------------------------------------------------------------
// c8e_fb
// Framebuffer byte RAM, 256 bytes, with per-byte valid bits that reset and
// clear-screen wipe at once; an invalid byte reads as zero.
// ----------------------------------------------------------------------------
module c8e_fb (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clr_i,
  input  c8e_pkg::fb_req_t        req_i,
  output logic [7:0]              rdata_o
);

  localparam int unsigned Depth = 2**c8e_pkg::FbAw;

  logic [7:0]       mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [7:0]       rd_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rd_q <= mem_q[req_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[req_i.addr] && !clr_i;
      if (clr_i) begin
        vld_q <= '0;
      end else if (req_i.we) begin
        vld_q[req_i.addr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvld_q ? rd_q : 8'h00;

endmodule

FILE: rtl/c8e_seq.sv
// ----------------------------------------------------------------------------
// c8e_seq
// Sequencer and register file: decodes one request and walks memory through
// a shared adder (index plus offset) and the framebuffer by pixel index.
// ----------------------------------------------------------------------------
module c8e_seq #(
  parameter int unsigned StackDepth = c8e_pkg::StackDepthDef,
  parameter int unsigned FontBase   = c8e_pkg::FontBaseDef,
  parameter int unsigned FontHeight = c8e_pkg::FontHeightDef,
  parameter int unsigned StepSize   = c8e_pkg::StepSizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  c8e_pkg::req_t       req_i,
  output logic                busy_o,
  output logic                done_o,
  output c8e_pkg::rsp_t       rsp_o,
  output c8e_pkg::mem_req_t   mem_o,
  input  logic [7:0]          mem_rdata_i,
  output c8e_pkg::fb_req_t    fb_o,
  output logic                fb_clr_o,
  input  logic [7:0]          fb_rdata_i
);

  localparam int unsigned SpW = $clog2(StackDepth);
  localparam int unsigned DcW = $clog2(StackDepth + 1);
  localparam logic [11:0] Step = 12'(StepSize);
  localparam logic [15:0] FontB = 16'(FontBase);
  localparam logic [15:0] FontH = 16'(FontHeight);

  c8e_pkg::state_e state_q, state_d;
  c8e_pkg::req_t   req_q;

  logic [7:0]  v_q [16];
  logic [15:0] i_q;
  logic [11:0] pc_q;
  logic [11:0] stk_q [StackDepth];
  logic [DcW-1:0] dep_q;
  logic [7:0]  dt_q, st_q;

  logic [3:0]  cnt_q;
  logic [2:0]  sub_q;
  logic [7:0]  row_q;
  logic        hit_q;
  logic [1:0]  status_q;
  logic [7:0]  rd_q;
  logic        coll_q;

  logic [3:0]  opc, xi, yi, nl;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [7:0]  vx, vy;
  logic [7:0]  bcd_h, bcd_t, bcd_o, bcd_r;
  logic [15:0] bcd_m;
  logic [5:0]  px;
  logic [4:0]  py;
  logic [10:0] pidx;
  logic [15:0] sum;

  assign opc = req_q.instruction[15:12];
  assign xi  = req_q.instruction[11:8];
  assign yi  = req_q.instruction[7:4];
  assign nl  = req_q.instruction[3:0];
  assign nn  = req_q.instruction[7:0];
  assign nnn = req_q.instruction[11:0];
  assign vx  = v_q[xi];
  assign vy  = v_q[yi];

  // shared adder: index plus walk offset
  assign sum = i_q + {12'd0, cnt_q};

  assign px   = 6'(vx) + 6'(sub_q);
  assign py   = 5'(vy) + 5'(cnt_q);
  assign pidx = {py, px};

  always_comb begin
    bcd_h = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
    bcd_r = vx - 8'(bcd_h * 8'd100);
    // tens by reciprocal multiply, exact for the remainder below 100
    bcd_m = {8'd0, bcd_r} * 16'd205;
    bcd_t = {3'd0, bcd_m[15:11]};
    bcd_o = bcd_r - 8'(bcd_t * 8'd10);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      c8e_pkg::S_IDLE: if (start_i) state_d = c8e_pkg::S_DECODE;
      c8e_pkg::S_DECODE: begin
        state_d = c8e_pkg::S_DONE;
        case (c8e_pkg::op_e'(req_q.op))
          c8e_pkg::OP_MWR:  state_d = c8e_pkg::S_DONE;
          c8e_pkg::OP_MRD:  state_d = c8e_pkg::S_MEM_WAIT;
          c8e_pkg::OP_FBRD: state_d = c8e_pkg::S_FB_WAIT;
          default: begin
            if (req_q.instruction == c8e_pkg::InsCls) state_d = c8e_pkg::S_CLEAR;
            else if (opc == 4'hD && nl != 4'd0) state_d = c8e_pkg::S_DRAW_RD;
            else if (opc == 4'hF && nn == c8e_pkg::FnBcd) state_d = c8e_pkg::S_BCD;
            else if (opc == 4'hF && nn == c8e_pkg::FnStore) state_d = c8e_pkg::S_STORE;
            else if (opc == 4'hF && nn == c8e_pkg::FnLoad) state_d = c8e_pkg::S_LOAD_RD;
          end
        endcase
      end
      c8e_pkg::S_CLEAR:     state_d = c8e_pkg::S_DONE;
      c8e_pkg::S_DRAW_RD:   state_d = c8e_pkg::S_DRAW_WAIT;
      c8e_pkg::S_DRAW_WAIT: state_d = c8e_pkg::S_DRAW_PIX;
      c8e_pkg::S_DRAW_PIX: begin
        if (sub_q == 3'd7) begin
          state_d = (cnt_q == nl - 4'd1) ? c8e_pkg::S_DONE : c8e_pkg::S_DRAW_RD;
        end else begin
          state_d = c8e_pkg::S_DRAW_WAIT;
        end
      end
      c8e_pkg::S_BCD:       if (cnt_q == 4'd2) state_d = c8e_pkg::S_DONE;
      c8e_pkg::S_STORE:     if (cnt_q == xi) state_d = c8e_pkg::S_DONE;
      c8e_pkg::S_LOAD_RD:   state_d = c8e_pkg::S_LOAD_WAIT;
      c8e_pkg::S_LOAD_WAIT: begin
        state_d = (cnt_q == xi) ? c8e_pkg::S_DONE : c8e_pkg::S_LOAD_RD;
      end
      c8e_pkg::S_MEM_WAIT:  state_d = c8e_pkg::S_DONE;
      c8e_pkg::S_FB_WAIT:   state_d = c8e_pkg::S_DONE;
      c8e_pkg::S_DONE:      state_d = c8e_pkg::S_IDLE;
      default:              state_d = c8e_pkg::S_IDLE;
    endcase
  end

  // memory and framebuffer port drive
  always_comb begin
    mem_o    = '{we: 1'b0, addr: sum[11:0], wdata: 8'h00};
    fb_o     = '{we: 1'b0, addr: pidx[10:3], wdata: 8'h00};
    fb_clr_o = 1'b0;
    case (state_q)
      c8e_pkg::S_DECODE: begin
        if (req_q.op == c8e_pkg::OP_MWR) begin
          mem_o = '{we: 1'b1, addr: req_q.address, wdata: req_q.write_data};
        end else if (req_q.op == c8e_pkg::OP_MRD) begin
          mem_o.addr = req_q.address;
        end
        if (req_q.op == c8e_pkg::OP_FBRD) begin
          fb_o.addr = req_q.address[7:0];
        end
      end
      c8e_pkg::S_CLEAR: fb_clr_o = 1'b1;
      c8e_pkg::S_DRAW_PIX: begin
        fb_o.we    = row_q[3'd7 - sub_q];
        fb_o.wdata = fb_rdata_i ^ (8'h80 >> pidx[2:0]);
      end
      c8e_pkg::S_BCD: begin
        mem_o.we    = 1'b1;
        mem_o.wdata = (cnt_q == 4'd0) ? bcd_h : (cnt_q == 4'd1) ? bcd_t : bcd_o;
      end
      c8e_pkg::S_STORE: begin
        mem_o.we    = 1'b1;
        mem_o.wdata = v_q[cnt_q];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c8e_pkg::S_IDLE;
      i_q     <= '0;
      pc_q    <= 12'h200;
      dep_q   <= '0;
      dt_q    <= '0;
      st_q    <= '0;
      for (int k = 0; k < 16; k++) v_q[k] <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        c8e_pkg::S_DECODE: begin
          if (req_q.op == c8e_pkg::OP_EXEC) begin
            case (opc)
              4'h0: begin
                if (req_q.instruction == c8e_pkg::InsCls) pc_q <= pc_q + Step;
                else if (req_q.instruction == c8e_pkg::InsRet && dep_q != '0) begin
                  dep_q <= dep_q - DcW'(1);
                  pc_q  <= stk_q[SpW'(dep_q - DcW'(1))] + Step;
                end
              end
              4'h1: pc_q <= nnn;
              4'h2: if (dep_q < DcW'(StackDepth)) begin
                dep_q <= dep_q + DcW'(1);
                pc_q  <= nnn;
              end
              4'h3: pc_q <= pc_q + ((vx == nn) ? 12'(2 * StepSize) : Step);
              4'h4: pc_q <= pc_q + ((vx != nn) ? 12'(2 * StepSize) : Step);
              4'h5: pc_q <= pc_q + ((vx == vy) ? 12'(2 * StepSize) : Step);
              4'h6: begin v_q[xi] <= nn; pc_q <= pc_q + Step; end
              4'h7: begin v_q[xi] <= vx + nn; pc_q <= pc_q + Step; end
              4'h9: pc_q <= pc_q + ((vx != vy) ? 12'(2 * StepSize) : Step);
              4'hA: begin i_q <= {4'd0, nnn}; pc_q <= pc_q + Step; end
              4'hB: pc_q <= nnn + {4'd0, v_q[0]};
              4'hC: begin v_q[xi] <= req_q.random_byte & nn; pc_q <= pc_q + Step; end
              4'hD: if (nl == 4'd0) begin v_q[15] <= 8'd0; pc_q <= pc_q + Step; end
              4'hF: begin
                case (nn)
                  c8e_pkg::FnGetDt: begin v_q[xi] <= dt_q; pc_q <= pc_q + Step; end
                  c8e_pkg::FnSetDt: begin dt_q <= vx; pc_q <= pc_q + Step; end
                  c8e_pkg::FnSetSt: begin st_q <= vx; pc_q <= pc_q + Step; end
                  c8e_pkg::FnAddI:  begin i_q <= i_q + {8'd0, vx}; pc_q <= pc_q + Step; end
                  c8e_pkg::FnFont: begin
                    i_q  <= FontB + 16'({8'd0, vx} * FontH);
                    pc_q <= pc_q + Step;
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
        c8e_pkg::S_CLEAR: ;
        c8e_pkg::S_DRAW_PIX: begin
          if (sub_q == 3'd7 && cnt_q == nl - 4'd1) begin
            v_q[15] <= {7'd0, hit_q | (row_q[0] & |(fb_rdata_i & (8'h80 >> pidx[2:0])))};
            pc_q    <= pc_q + Step;
          end
        end
        c8e_pkg::S_BCD: if (cnt_q == 4'd2) pc_q <= pc_q + Step;
        c8e_pkg::S_STORE: if (cnt_q == xi) begin
          i_q  <= i_q + {12'd0, xi} + 16'd1;
          pc_q <= pc_q + Step;
        end
        c8e_pkg::S_LOAD_WAIT: begin
          v_q[cnt_q] <= mem_rdata_i;
          if (cnt_q == xi) begin
            i_q  <= i_q + {12'd0, xi} + 16'd1;
            pc_q <= pc_q + Step;
          end
        end
        default: ;
      endcase
    end
  end

  // pc after a clear is advanced in decode; stack write needs no reset
  always_ff @(posedge clk_i) begin
    if (state_q == c8e_pkg::S_DECODE && req_q.op == c8e_pkg::OP_EXEC && opc == 4'h2
        && dep_q < DcW'(StackDepth)) begin
      stk_q[SpW'(dep_q)] <= pc_q;
    end
  end

  // datapath work registers
  always_ff @(posedge clk_i) begin
    if (state_q == c8e_pkg::S_IDLE && start_i) req_q <= req_i;
    case (state_q)
      c8e_pkg::S_DECODE: begin
        cnt_q  <= '0;
        sub_q  <= '0;
        hit_q  <= 1'b0;
        rd_q   <= 8'h00;
        coll_q <= 1'b0;
        status_q <= c8e_pkg::ST_OK;
        if (req_q.op == c8e_pkg::OP_EXEC) begin
          case (opc)
            4'h0: begin
              if (req_q.instruction == c8e_pkg::InsRet) begin
                if (dep_q == '0) status_q <= c8e_pkg::ST_STACK;
              end else if (req_q.instruction != c8e_pkg::InsCls) begin
                status_q <= c8e_pkg::ST_ILL;
              end
            end
            4'h2: if (dep_q >= DcW'(StackDepth)) status_q <= c8e_pkg::ST_STACK;
            4'h8, 4'hE: status_q <= c8e_pkg::ST_UNIMP;
            4'hF: begin
              case (nn)
                c8e_pkg::FnKey: status_q <= c8e_pkg::ST_UNIMP;
                c8e_pkg::FnGetDt, c8e_pkg::FnSetDt, c8e_pkg::FnSetSt, c8e_pkg::FnAddI,
                c8e_pkg::FnFont, c8e_pkg::FnBcd, c8e_pkg::FnStore, c8e_pkg::FnLoad: ;
                default: status_q <= c8e_pkg::ST_ILL;
              endcase
            end
            default: ;
          endcase
        end
      end
      c8e_pkg::S_DRAW_WAIT: if (sub_q == 3'd0) row_q <= mem_rdata_i;
      c8e_pkg::S_DRAW_PIX: begin
        if (row_q[3'd7 - sub_q] && |(fb_rdata_i & (8'h80 >> pidx[2:0]))) hit_q <= 1'b1;
        sub_q <= sub_q + 3'd1;
        if (sub_q == 3'd7) begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == nl - 4'd1) begin
            coll_q <= hit_q | (row_q[0] & |(fb_rdata_i & (8'h80 >> pidx[2:0])));
          end
        end
      end
      c8e_pkg::S_BCD, c8e_pkg::S_STORE, c8e_pkg::S_LOAD_WAIT: cnt_q <= cnt_q + 4'd1;
      c8e_pkg::S_MEM_WAIT: rd_q <= mem_rdata_i;
      c8e_pkg::S_FB_WAIT: rd_q <= (req_q.address[11:8] == 4'd0) ? fb_rdata_i : 8'h00;
      default: ;
    endcase
  end

  assign busy_o = (state_q != c8e_pkg::S_IDLE);
  assign done_o = (state_q == c8e_pkg::S_DONE);

  always_comb begin
    rsp_o.program_counter = pc_q;
    rsp_o.status          = status_q;
    rsp_o.read_data       = rd_q;
    rsp_o.collision       = coll_q;
  end

endmodule

FILE: rtl/chip8_instruction_executor.sv
// ----------------------------------------------------------------------------
// chip8_instruction_executor
// Executes one instruction, memory access or framebuffer read per request.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low; busy
// then stays high until the result has been shown. The result is on rsp_o for
// exactly one cycle, marked by done_o; the receiver cannot stall it.
// Steps after decode, by kind of request:
//   plain instructions, memory write: none
//   memory or framebuffer read: one wait for the read data; clear: one wipe
//   BCD store: one memory write per digit;  Fx55: one write per V0..Vx;
//   Fx65: one read per V0..Vx;  sprite draw Dxyn: per row one memory read, then
//   per pixel one framebuffer read-modify-write over the single framebuffer port
// Next request may start the cycle after done_o. Reset clears V registers,
// index, stack depth, timers and the framebuffer valid bits (screen reads
// blank) at once and sets pc to 200h; byte memory is undefined until written.
// ----------------------------------------------------------------------------
module chip8_instruction_executor #(
  parameter int unsigned StackDepth = c8e_pkg::StackDepthDef,
  parameter int unsigned FontBase   = c8e_pkg::FontBaseDef,
  parameter int unsigned FontHeight = c8e_pkg::FontHeightDef,
  parameter int unsigned StepSize   = c8e_pkg::StepSizeDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  c8e_pkg::req_t req_i,
  output logic          done_o,
  output c8e_pkg::rsp_t rsp_o
);

  c8e_pkg::mem_req_t mem_req;
  c8e_pkg::fb_req_t  fb_req;
  logic [7:0]        mem_rdata, fb_rdata;
  logic              fb_clr;

  c8e_seq #(
    .StackDepth(StackDepth), .FontBase(FontBase),
    .FontHeight(FontHeight), .StepSize(StepSize)
  ) u_seq (
    .clk_i, .rst_ni, .start_i(start), .req_i, .busy_o(busy), .done_o, .rsp_o,
    .mem_o(mem_req), .mem_rdata_i(mem_rdata),
    .fb_o(fb_req), .fb_clr_o(fb_clr), .fb_rdata_i(fb_rdata)
  );

  c8e_mem #(.Aw(c8e_pkg::MemAw)) u_mem (
    .clk_i, .we_i(mem_req.we), .addr_i(mem_req.addr),
    .wdata_i(mem_req.wdata), .rdata_o(mem_rdata)
  );

  c8e_fb u_fb (
    .clk_i, .rst_ni, .clr_i(fb_clr), .req_i(fb_req), .rdata_o(fb_rdata)
  );

endmodule

FILE: rtl/c8e_chk.sv
// ----------------------------------------------------------------------------
// c8e_chk
// Port checker for the executor, bound to the top level.
// ----------------------------------------------------------------------------
module c8e_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input c8e_pkg::rsp_t rsp_o
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result without request");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_free_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("still busy after result");
  a_no_coll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != c8e_pkg::ST_OK |-> !rsp_o.collision)
    else $error("collision on failed request");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request not taken");

endmodule

bind chip8_instruction_executor c8e_chk u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .rsp_o
);
